FILE: rtl/bisc_pkg.sv
// ----------------------------------------------------------------------------
// bisc_pkg - banked interrupt status controller package
// Widths, opcodes, defaults and the request/result structs shared by the block.
// ----------------------------------------------------------------------------
package bisc_pkg;

  localparam int NUM_BANKS_DEF  = 10;
  localparam int MULTI_PINS_DEF = 10;
  localparam int LINES_DEF      = 32;

  localparam int OP_W   = 3;
  localparam int BANK_W = 4;
  localparam int DATA_W = 32;
  localparam int PIN_W  = 19;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  typedef enum logic [OP_W-1:0] {
    OP_EVENT     = 3'd0,
    OP_WR_ENABLE = 3'd1,
    OP_WR_STATUS = 3'd2,
    OP_RD_ENABLE = 3'd3,
    OP_RD_STATUS = 3'd4
  } opcode_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BANK_W-1:0] bank;
    logic              level;
    logic [DATA_W-1:0] source_lines;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [PIN_W-1:0]  pin_levels;
    logic              bad_write;
  } res_t;

endpackage

FILE: rtl/bisc_if.sv
// ----------------------------------------------------------------------------
// bisc_if - request and result channels
// Valid/ready channels carrying the controller's request and result fields.
// ----------------------------------------------------------------------------
interface bisc_req_if;
  logic                        valid;
  logic                        ready;
  logic [bisc_pkg::OP_W-1:0]   opcode;
  logic [bisc_pkg::BANK_W-1:0] bank;
  logic                        level;
  logic [bisc_pkg::DATA_W-1:0] source_lines;
  logic [bisc_pkg::DATA_W-1:0] write_data;

  modport source (output valid, opcode, bank, level, source_lines, write_data,
                  input ready);
  modport sink   (input valid, opcode, bank, level, source_lines, write_data,
                  output ready);
endinterface

interface bisc_res_if;
  logic                        valid;
  logic                        ready;
  logic [bisc_pkg::DATA_W-1:0] read_data;
  logic [bisc_pkg::PIN_W-1:0]  pin_levels;
  logic                        bad_write;

  modport source (output valid, read_data, pin_levels, bad_write, input ready);
  modport sink   (input valid, read_data, pin_levels, bad_write, output ready);
endinterface

FILE: rtl/banked_interrupt_status_controller.sv
// ----------------------------------------------------------------------------
// banked_interrupt_status_controller - banked interrupt status controller
// Per-bank enable, mask, pending and write-one-to-clear status with output
// pins; one request in, one result out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      carries
//  in_ch     in   valid/ready    opcode, bank, level, source_lines, write_data
//  out_ch    out  valid/ready    read_data, pin_levels, bad_write
//
//  One request per cycle while out_ch.ready stays high. A request enters the
//  input register at its accepting edge; the bank update then loads the result
//  register once it has room, and the result leaves from there.
//  The bank update is a single pass over one bank's registers.
//  Synchronous reset clears all bank registers and pins.
//  out_ch.ready low holds the result and, once the input register is full,
//  drops in_ch.ready.
// ----------------------------------------------------------------------------
module banked_interrupt_status_controller #(
  parameter int NUM_BANKS  = bisc_pkg::NUM_BANKS_DEF,
  parameter int MULTI_PINS = bisc_pkg::MULTI_PINS_DEF,
  parameter int LINES      = bisc_pkg::LINES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bisc_req_if.sink   in_ch,
  bisc_res_if.source out_ch
);

  bisc_pkg::req_t in_req;
  bisc_pkg::req_t req;
  bisc_pkg::res_t res;
  bisc_pkg::res_t out_res;
  logic           commit;
  logic           out_room;
  logic           in_ready;
  logic           out_valid;

  assign in_req.opcode       = in_ch.opcode;
  assign in_req.bank         = in_ch.bank;
  assign in_req.level        = in_ch.level;
  assign in_req.source_lines = in_ch.source_lines;
  assign in_req.write_data   = in_ch.write_data;
  assign in_ch.ready         = in_ready;

  bisc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_room (out_room),
    .commit   (commit),
    .req      (req)
  );

  bisc_core #(
    .NUM_BANKS  (NUM_BANKS),
    .MULTI_PINS (MULTI_PINS),
    .LINES      (LINES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .req    (req),
    .res    (res)
  );

  bisc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (commit),
    .res       (res),
    .out_room  (out_room),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.read_data  = out_res.read_data;
  assign out_ch.pin_levels = out_res.pin_levels;
  assign out_ch.bad_write  = out_res.bad_write;

endmodule

FILE: rtl/bisc_in_reg.sv
// ----------------------------------------------------------------------------
// bisc_in_reg - request input register
// Captures one request per cycle; hands it to the core when the result
// register has room.
// ----------------------------------------------------------------------------
module bisc_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bisc_pkg::req_t in_req,
  input  logic           out_room,
  output logic           commit,
  output bisc_pkg::req_t req
);

  logic           valid_r;
  logic           valid_nxt;
  bisc_pkg::req_t req_r;

  assign commit    = valid_r && out_room;
  assign in_ready  = !valid_r || out_room;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !out_room);
  assign req       = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

endmodule

FILE: rtl/bisc_core.sv
// ----------------------------------------------------------------------------
// bisc_core - bank register file and update logic
// Holds every bank's enable, mask, pending, enable word and status, plus the
// pin levels; applies one request per commit.
// ----------------------------------------------------------------------------
module bisc_core #(
  parameter int NUM_BANKS  = bisc_pkg::NUM_BANKS_DEF,
  parameter int MULTI_PINS = bisc_pkg::MULTI_PINS_DEF,
  parameter int LINES      = bisc_pkg::LINES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           commit,
  input  bisc_pkg::req_t req,
  output bisc_pkg::res_t res
);

  localparam int DW = bisc_pkg::DATA_W;
  localparam int PW = bisc_pkg::PIN_W;
  localparam logic [DW-1:0] LINE_MASK = DW'((64'd1 << LINES) - 64'd1);
  localparam logic [DW-1:0] M0_MASK   = DW'((64'd1 << MULTI_PINS) - 64'd1);
  localparam logic [5:0]    NB        = 6'(NUM_BANKS);
  localparam logic [5:0]    PIN_BASE  = 6'(MULTI_PINS - 1);

  // pins that some bank can drive
  function automatic logic [PW-1:0] used_pins();
    logic [PW-1:0] m;
    m = '0;
    for (int i = 0; i < PW; i++) begin
      if (i < MULTI_PINS + NUM_BANKS - 1) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  localparam logic [PW-1:0] USED_PINS = used_pins();

  logic [DW-1:0] en_r   [NUM_BANKS];
  logic [DW-1:0] isr_r  [NUM_BANKS];
  logic [DW-1:0] pend_r [NUM_BANKS];
  logic [DW-1:0] ew_r   [NUM_BANKS];
  logic [DW-1:0] st_r   [NUM_BANKS];
  logic [PW-1:0] pin_r;

  logic [NUM_BANKS-1:0] hit;
  logic                 bank_ok;
  logic                 is_b0;
  logic [5:0]           bank_pin;
  logic [DW-1:0]        cur_en, cur_isr, cur_pend, cur_ew, cur_st;
  logic [DW-1:0]        en_nxt, isr_nxt, pend_nxt, ew_nxt, st_nxt;
  logic [PW-1:0]        pin_nxt;
  logic [DW-1:0]        rd;
  logic                 bad;
  logic [DW-1:0]        sel, sel0, defer, fresh, chg, wbits, rel, st_clr;

  assign bank_ok  = {2'b00, req.bank} < NB;
  assign is_b0    = req.bank == '0;
  assign bank_pin = PIN_BASE + {2'b00, req.bank};

  always_comb begin
    cur_en   = '0;
    cur_isr  = '0;
    cur_pend = '0;
    cur_ew   = '0;
    cur_st   = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      hit[b] = bank_ok && ({2'b00, req.bank} == 6'(b));
      if (hit[b]) begin
        cur_en   = en_r[b];
        cur_isr  = isr_r[b];
        cur_pend = pend_r[b];
        cur_ew   = ew_r[b];
        cur_st   = st_r[b];
      end
    end
  end

  always_comb begin
    en_nxt   = cur_en;
    isr_nxt  = cur_isr;
    pend_nxt = cur_pend;
    ew_nxt   = cur_ew;
    st_nxt   = cur_st;
    pin_nxt  = pin_r;
    rd       = '0;
    bad      = 1'b0;
    sel      = req.source_lines & cur_en & LINE_MASK;
    sel0     = sel & M0_MASK;
    defer    = sel0 & (cur_isr | cur_st);
    fresh    = sel0 & ~defer;
    chg      = cur_ew ^ req.write_data;
    wbits    = req.write_data & M0_MASK;
    rel      = wbits & cur_pend;
    st_clr   = cur_st & ~req.write_data;
    if (bank_ok) begin
      case (req.opcode)
        bisc_pkg::OP_EVENT: begin
          if (req.level && (sel != '0)) begin
            if (is_b0) begin
              pend_nxt = cur_pend | defer;
              st_nxt   = cur_st | fresh;
              for (int i = 0; i < PW; i++) begin
                if (i < MULTI_PINS && fresh[i]) begin
                  pin_nxt[i] = 1'b1;
                end
              end
            end else if ((sel & (cur_isr | cur_st)) != '0) begin
              pend_nxt = cur_pend | sel;
            end else begin
              st_nxt = sel;
              for (int i = 0; i < PW; i++) begin
                if (6'(i) == bank_pin) begin
                  pin_nxt[i] = 1'b1;
                end
              end
            end
          end
        end
        bisc_pkg::OP_WR_ENABLE: begin
          ew_nxt = req.write_data;
          if ((cur_en | req.write_data) != cur_en) begin
            en_nxt = cur_en | req.write_data;
          end else if (req.write_data != '0 || cur_en != '0) begin
            // no new enable bit: the changed bits mask or unmask
            if ((chg & req.write_data) != '0) begin
              isr_nxt = cur_isr & ~chg;
            end else begin
              isr_nxt = cur_isr | chg;
            end
          end
        end
        bisc_pkg::OP_WR_STATUS: begin
          if (req.write_data == '0) begin
            bad = 1'b1;
          end else begin
            st_nxt = st_clr;
            if (req.write_data != bisc_pkg::ALL_ONES) begin
              if (is_b0) begin
                st_nxt   = st_clr | rel;
                pend_nxt = cur_pend & ~rel;
                for (int i = 0; i < PW; i++) begin
                  if (i < MULTI_PINS && wbits[i]) begin
                    pin_nxt[i] = cur_pend[i];
                  end
                end
              end else if (st_clr == '0) begin
                // drained: reload from pending
                st_nxt   = cur_pend;
                pend_nxt = '0;
                for (int i = 0; i < PW; i++) begin
                  if (6'(i) == bank_pin) begin
                    pin_nxt[i] = cur_pend != '0;
                  end
                end
              end
            end
          end
        end
        bisc_pkg::OP_RD_ENABLE: rd = cur_ew;
        bisc_pkg::OP_RD_STATUS: rd = cur_st;
        default: ;
      endcase
    end
  end

  assign res.read_data  = rd;
  assign res.pin_levels = pin_nxt;
  assign res.bad_write  = bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r <= '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
        en_r[b]   <= '0;
        isr_r[b]  <= '0;
        pend_r[b] <= '0;
        ew_r[b]   <= '0;
        st_r[b]   <= '0;
      end
    end else if (commit) begin
      pin_r <= pin_nxt;
      for (int b = 0; b < NUM_BANKS; b++) begin
        if (hit[b]) begin
          en_r[b]   <= en_nxt;
          isr_r[b]  <= isr_nxt;
          pend_r[b] <= pend_nxt;
          ew_r[b]   <= ew_nxt;
          st_r[b]   <= st_nxt;
        end
      end
    end
  end

  // pins move only on a committed request
  a_pin_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(pin_r))
    else $error("pin levels changed without a request");

  // no pin outside the bank map is ever raised
  a_pin_map: assert property (@(posedge clk) disable iff (!rst_n)
    (pin_r & ~USED_PINS) == '0)
    else $error("unmapped pin raised");

  a_bad_write: assert property (@(posedge clk) disable iff (!rst_n)
    res.bad_write |-> (req.opcode == bisc_pkg::OP_WR_STATUS) &&
                      (req.write_data == '0) && bank_ok)
    else $error("bad_write flagged on a valid request");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (req.opcode != bisc_pkg::OP_RD_ENABLE && req.opcode != bisc_pkg::OP_RD_STATUS)
      |-> res.read_data == '0)
    else $error("read data on a non-read request");

endmodule

FILE: rtl/bisc_out_reg.sv
// ----------------------------------------------------------------------------
// bisc_out_reg - result register
// Holds one result until the sink takes it; reports room to the input side.
// ----------------------------------------------------------------------------
module bisc_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           commit,
  input  bisc_pkg::res_t res,
  output logic           out_room,
  output logic           out_valid,
  input  logic           out_ready,
  output bisc_pkg::res_t out_res
);

  logic           valid_r;
  logic           valid_nxt;
  bisc_pkg::res_t res_r;

  assign out_room  = !valid_r || out_ready;
  assign valid_nxt = commit || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_r <= res;
    end
  end

endmodule

FILE: tb/sv/bisc_status_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bisc_status_checker - result checker for the banked interrupt controller
// Watches both channels, keeps its own copy of the bank registers and pins,
// predicts the result of every accepted request and compares it field by field
// with the results as they leave the block.
// ----------------------------------------------------------------------------
module bisc_status_checker
  import bisc_pkg::*;
#(
  parameter int NUM_BANKS  = NUM_BANKS_DEF,
  parameter int MULTI_PINS = MULTI_PINS_DEF,
  parameter int LINES      = LINES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bisc_req_if  req_ch,
  bisc_res_if  res_ch,
  output int   fail_count,
  output int   awaited,
  output int   checked
);

  localparam logic [DATA_W-1:0] LINE_MASK = DATA_W'((64'd1 << LINES) - 64'd1);

  logic [DATA_W-1:0] armed_lines    [NUM_BANKS];
  logic [DATA_W-1:0] held_mask      [NUM_BANKS];
  logic [DATA_W-1:0] deferred_lines [NUM_BANKS];
  logic [DATA_W-1:0] last_enable    [NUM_BANKS];
  logic [DATA_W-1:0] status_word    [NUM_BANKS];
  logic [PIN_W-1:0]  pin_image;

  res_t due_results[$];

  function automatic void set_pin(int idx, logic lvl);
    if (idx < PIN_W) pin_image[idx] = lvl;
  endfunction

  task automatic update_banks(input req_t rq, output res_t rs);
    logic [DATA_W-1:0] hit;
    logic [DATA_W-1:0] bitv;
    logic [DATA_W-1:0] chg;
    logic [DATA_W-1:0] prior;
    int b;
    rs = '0;
    b = int'(rq.bank);
    if (b < NUM_BANKS) begin
      case (opcode_t'(rq.opcode))
        OP_EVENT: begin
          hit = rq.source_lines & armed_lines[b] & LINE_MASK;
          if (rq.level && hit != '0) begin
            if (b == 0) begin
              // each low bit of bank 0 has its own pin; higher bits are dropped
              for (int i = 0; i < MULTI_PINS && i < DATA_W; i++) begin
                bitv = DATA_W'(1) << i;
                if ((hit & bitv) != '0) begin
                  if (((held_mask[0] | status_word[0]) & bitv) != '0) begin
                    deferred_lines[0] |= bitv;
                  end else begin
                    status_word[0] |= bitv;
                    set_pin(i, 1'b1);
                  end
                end
              end
            end else if (((held_mask[b] | status_word[b]) & hit) != '0) begin
              deferred_lines[b] |= hit;
            end else begin
              status_word[b] = hit;
              set_pin(MULTI_PINS - 1 + b, 1'b1);
            end
          end
        end
        OP_WR_ENABLE: begin
          prior = armed_lines[b];
          armed_lines[b] = prior | rq.write_data;
          // no new enable bit: the changed bits mask or unmask
          if (armed_lines[b] == prior && !(prior == '0 && rq.write_data == '0)) begin
            chg = last_enable[b] ^ rq.write_data;
            if ((chg & rq.write_data) != '0) held_mask[b] &= ~chg;
            else held_mask[b] |= chg;
          end
          last_enable[b] = rq.write_data;
        end
        OP_WR_STATUS: begin
          if (rq.write_data == '0) begin
            rs.bad_write = 1'b1;
          end else begin
            status_word[b] &= ~rq.write_data;
            // all ones only clears: no reload, pins untouched
            if (rq.write_data != ALL_ONES) begin
              if (b == 0) begin
                for (int i = 0; i < MULTI_PINS && i < DATA_W; i++) begin
                  bitv = DATA_W'(1) << i;
                  if ((rq.write_data & bitv) != '0) begin
                    if ((deferred_lines[0] & bitv) != '0) begin
                      status_word[0] |= bitv;
                      deferred_lines[0] &= ~bitv;
                      set_pin(i, 1'b1);
                    end else begin
                      set_pin(i, 1'b0);
                    end
                  end
                end
              end else if (status_word[b] == '0) begin
                if (deferred_lines[b] != '0) begin
                  status_word[b] = deferred_lines[b];
                  deferred_lines[b] = '0;
                  set_pin(MULTI_PINS - 1 + b, 1'b1);
                end else begin
                  set_pin(MULTI_PINS - 1 + b, 1'b0);
                end
              end
            end
          end
        end
        OP_RD_ENABLE: rs.read_data = last_enable[b];
        OP_RD_STATUS: rs.read_data = status_word[b];
        default: ;
      endcase
    end
    rs.pin_levels = pin_image;
  endtask

  always @(posedge clk) begin
    res_t due;
    req_t rq;
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        armed_lines[i]    = '0;
        held_mask[i]      = '0;
        deferred_lines[i] = '0;
        last_enable[i]    = '0;
        status_word[i]    = '0;
      end
      pin_image = '0;
      due_results.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          due = due_results.pop_front();
          checked++;
          if (res_ch.read_data !== due.read_data) begin
            $error("read_data: expected %h, got %h", due.read_data, res_ch.read_data);
            fail_count++;
          end
          if (res_ch.pin_levels !== due.pin_levels) begin
            $error("pin_levels: expected %h, got %h", due.pin_levels, res_ch.pin_levels);
            fail_count++;
          end
          if (res_ch.bad_write !== due.bad_write) begin
            $error("bad_write: expected %b, got %b", due.bad_write, res_ch.bad_write);
            fail_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        rq = '{opcode: req_ch.opcode, bank: req_ch.bank, level: req_ch.level,
               source_lines: req_ch.source_lines, write_data: req_ch.write_data};
        update_banks(rq, due);
        due_results.push_back(due);
      end
    end
    awaited = due_results.size();
  end

endmodule

FILE: tb/sv/banked_interrupt_status_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// banked_interrupt_status_controller_tb - testbench top
// Drives a directed opening and then randomised bank sessions (enable, events,
// status reads and clears) with random gaps on both channels, a long result
// stall and one full drain; the checker beside the block gives the verdict.
// ----------------------------------------------------------------------------
module banked_interrupt_status_controller_tb;
  import bisc_pkg::*;

  localparam int NUM_BANKS     = NUM_BANKS_DEF;
  localparam int MULTI_PINS    = MULTI_PINS_DEF;
  localparam int LINES         = LINES_DEF;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int MAX_GAP       = 17;
  localparam int HOLD_AT       = 400;
  localparam int LONG_HOLD     = 150;
  localparam int DRAIN_AT      = 900;
  localparam int LAST_BANK     = (1 << BANK_W) - 1;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam logic [DATA_W-1:0] PIN0_BITS = DATA_W'((64'd1 << MULTI_PINS) - 64'd1);

  logic clk = 1'b0;
  logic rst_n;

  bisc_req_if in_ch ();
  bisc_res_if out_ch ();

  int fail_count;
  int awaited;
  int checked;
  int sent;
  int n_event, n_enable, n_status, n_read, n_stray;
  logic tx_steady;

  banked_interrupt_status_controller #(
    .NUM_BANKS (NUM_BANKS),
    .MULTI_PINS(MULTI_PINS),
    .LINES     (LINES)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  bisc_status_checker #(
    .NUM_BANKS (NUM_BANKS),
    .MULTI_PINS(MULTI_PINS),
    .LINES     (LINES)
  ) u_status_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ch    (in_ch),
    .res_ch    (out_ch),
    .fail_count(fail_count),
    .awaited   (awaited),
    .checked   (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2, 3:    return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      4, 5:    return $urandom & PIN0_BITS;
      6, 7:    return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  // clears biased towards emptying status so that reloads happen
  function automatic logic [DATA_W-1:0] pick_clear();
    case ($urandom_range(0, 19))
      0:             return '0;
      1:             return ALL_ONES;
      2, 3, 4, 5, 6, 7: return ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
      8, 9, 10:      return DATA_W'(1) << $urandom_range(0, MULTI_PINS - 1);
      11, 12, 13:    return $urandom & PIN0_BITS;
      default:       return pick_word();
    endcase
  endfunction

  function automatic logic [BANK_W-1:0] pick_bank();
    if ($urandom_range(0, 24) == 0) return BANK_W'($urandom_range(NUM_BANKS, LAST_BANK));
    if ($urandom_range(0, 3) == 0) return '0;
    return BANK_W'($urandom_range(1, NUM_BANKS - 1));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [OP_W-1:0] op, input logic [BANK_W-1:0] bank,
                              input logic lvl, input logic [DATA_W-1:0] lines,
                              input logic [DATA_W-1:0] data);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.opcode       <= op;
    in_ch.bank         <= bank;
    in_ch.level        <= lvl;
    in_ch.source_lines <= lines;
    in_ch.write_data   <= data;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sent++;
    if (bank >= NUM_BANKS) n_stray++;
    case (op)
      OP_EVENT:                   n_event++;
      OP_WR_ENABLE:               n_enable++;
      OP_WR_STATUS:               n_status++;
      OP_RD_ENABLE, OP_RD_STATUS: n_read++;
      default:                    n_stray++;
    endcase
    if (sent % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int rnd;
    int n;
    logic [BANK_W-1:0] b;
    logic drained;
    sent = 0;
    n_event = 0; n_enable = 0; n_status = 0; n_read = 0; n_stray = 0;
    tx_steady = 1'b0;
    drained = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= '0;
    in_ch.bank         <= '0;
    in_ch.level        <= 1'b0;
    in_ch.source_lines <= '0;
    in_ch.write_data   <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening
    send_request(OP_RD_ENABLE, 4'd0, 1'b0, '0, '0);
    send_request(OP_EVENT,     4'd3, 1'b1, ALL_ONES, '0);       // nothing enabled
    send_request(OP_WR_ENABLE, 4'd5, 1'b0, '0, '0);             // zero onto zero
    send_request(OP_WR_ENABLE, 4'd3, 1'b0, '0, 32'h0000_00f0);
    send_request(OP_WR_ENABLE, 4'd0, 1'b1, '0, ALL_ONES);
    send_request(OP_EVENT,     4'd0, 1'b0, ALL_ONES, '0);       // level low
    send_request(OP_EVENT,     4'd0, 1'b1, 32'hffff_fc05, '0);  // high bits dropped
    send_request(OP_EVENT,     4'd0, 1'b1, 32'h0000_0007, '0);  // two to pending
    send_request(OP_WR_STATUS, 4'd0, 1'b0, '0, 32'h0000_0001);  // reload bit 0
    send_request(OP_WR_STATUS, 4'd0, 1'b0, '0, '0);             // flagged, ignored
    send_request(OP_EVENT,     4'd3, 1'b1, 32'h0000_0030, '0);
    send_request(OP_EVENT,     4'd3, 1'b1, 32'h0000_00c0, '0);
    send_request(OP_WR_STATUS, 4'd3, 1'b0, '0, 32'h0000_0010);
    send_request(OP_WR_STATUS, 4'd3, 1'b0, '0, 32'h0000_0020);  // status still holds 0xc0, no reload
    send_request(OP_WR_ENABLE, 4'd3, 1'b0, '0, 32'h0000_0030);  // masks 0xc0
    send_request(OP_EVENT,     4'd3, 1'b1, 32'h0000_00c0, '0);
    send_request(OP_WR_ENABLE, 4'd3, 1'b0, '0, 32'h0000_00f0);  // unmasks
    send_request(OP_WR_STATUS, 4'd3, 1'b0, '0, ALL_ONES);
    send_request(OP_RD_STATUS, 4'd3, 1'b0, '0, '0);
    send_request(OP_RD_ENABLE, 4'd3, 1'b0, '0, '0);
    send_request(OP_EVENT,     4'd12, 1'b1, ALL_ONES, '0);      // stray bank
    send_request(OP_WR_STATUS, 4'd15, 1'b0, '0, ALL_ONES);
    send_request(OP_UNUSED_HI, 4'd1, 1'b1, ALL_ONES, ALL_ONES);
    send_request(OP_WR_ENABLE, 4'd9, 1'b0, '0, ALL_ONES);
    send_request(OP_EVENT,     4'd9, 1'b1, ALL_ONES, '0);

    // random sessions on one bank, mixed with loose requests
    while (sent < RANDOM_ITEMS) begin
      if (!drained && sent >= DRAIN_AT) begin
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (awaited != 0);
      end
      if ($urandom_range(0, 9) < 7) begin
        b = pick_bank();
        if ($urandom_range(0, 1) == 0)
          send_request(OP_WR_ENABLE, b, 1'($urandom), $urandom, pick_word());
        n = $urandom_range(1, 3);
        repeat (n) send_request(OP_EVENT, b, 1'b1, pick_word(), $urandom);
        if ($urandom_range(0, 1) == 0)
          send_request(OP_RD_STATUS, b, 1'($urandom), $urandom, $urandom);
        n = $urandom_range(1, 3);
        repeat (n) send_request(OP_WR_STATUS, b, 1'($urandom), $urandom, pick_clear());
        if ($urandom_range(0, 9) < 3)
          send_request(OP_RD_ENABLE, b, 1'($urandom), $urandom, $urandom);
      end else begin
        rnd = $urandom_range(0, 99);
        if (rnd < 30)
          send_request(OP_EVENT, pick_bank(), 1'($urandom_range(0, 9) != 0),
                       pick_word(), $urandom);
        else if (rnd < 45)
          send_request(OP_WR_ENABLE, pick_bank(), 1'($urandom), $urandom, pick_word());
        else if (rnd < 70)
          send_request(OP_WR_STATUS, pick_bank(), 1'($urandom), $urandom, pick_clear());
        else if (rnd < 78)
          send_request(OP_RD_ENABLE, pick_bank(), 1'($urandom), $urandom, $urandom);
        else if (rnd < 96)
          send_request(OP_RD_STATUS, pick_bank(), 1'($urandom), $urandom, $urandom);
        else
          send_request(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), pick_bank(),
                       1'($urandom), $urandom, $urandom);
      end
    end

    in_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    repeat (8) @(negedge clk);
    $display("Sent %0d requests: %0d events, %0d enable writes, %0d status writes, %0d reads",
             sent, n_event, n_enable, n_status, n_read);
    $display("%0d stray bank or unused opcode requests; %0d results compared",
             n_stray, checked);
    if (fail_count == 0) begin
      $display("banked_interrupt_status_controller_tb passed");
    end else begin
      $display("banked_interrupt_status_controller_tb failed");
    end
    $finish;
  end

  initial begin : result_drain
    int stall;
    int taken;
    logic steady;
    taken = 0;
    steady = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      stall = steady ? 0 : $urandom_range(0, MAX_GAP);
      // long back-pressure: the block fills and drops in_ch.ready
      if (taken == HOLD_AT) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      taken++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("banked_interrupt_status_controller_tb failed");
    $finish;
  end

endmodule
